### hdl/lat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lat_pkg;

    // grid limits
    localparam int LAT_MAX_WIDTH  = 64;
    localparam int LAT_MAX_HEIGHT = 64;

    // field widths
    localparam int KIND_W = 2;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int SIZE_W = 7;

    // beat kinds
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

    // register select, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROT,
        ST_FIX
    } t_state;

    // control broadcast to every row cell
    typedef struct packed {
        logic             shift;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic [COL_W-1:0] wr_col;
        logic             wr_val;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hdl/lat_row_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lat_row_cell
    import lat_pkg::*;
#(
    parameter int MAX_WIDTH = LAT_MAX_WIDTH,
    parameter int INDEX     = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [MAX_WIDTH-1:0] i_shift_in,
    input  wire logic                 i_load,
    input  wire logic [MAX_WIDTH-1:0] i_load_row,
    output logic      [MAX_WIDTH-1:0] o_row
);

    logic [MAX_WIDTH-1:0] r_row;
    logic [MAX_WIDTH-1:0] n_row;
    logic                 row_hit;

    // rows beyond the address range of the port can never be hit
    assign row_hit = i_ctl.wr_en && (INDEX < (1 << ROW_W)) && (int'(i_ctl.wr_row) == INDEX);

    always_comb begin
        n_row = r_row;
        priority if (i_ctl.shift) begin
            n_row = i_shift_in;
        end else if (i_load) begin
            n_row = i_load_row;
        end else if (row_hit) begin
            for (int c = 0; c < MAX_WIDTH; c++) begin
                if (int'(i_ctl.wr_col) == c) begin
                    n_row[c] = i_ctl.wr_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_row = r_row;

endmodule

`default_nettype wire

### hdl/lat_row_rule.sv
`timescale 1ns / 1ps
`default_nettype none

module lat_row_rule
    import lat_pkg::*;
#(
    parameter int MAX_WIDTH = LAT_MAX_WIDTH
) (
    input  wire logic [MAX_WIDTH-1:0]           i_up,
    input  wire logic [MAX_WIDTH-1:0]           i_cur,
    input  wire logic [MAX_WIDTH-1:0]           i_dn,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0] i_width,
    output logic      [MAX_WIDTH-1:0]           o_next
);

    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int IW = $clog2(MAX_WIDTH);

    logic [EW-1:0]        wm1_full;
    logic [IW-1:0]        wm1;
    logic [MAX_WIDTH-1:0] up_l, up_r, cur_l, cur_r, dn_l, dn_r;

    assign wm1_full = i_width - EW'(1);
    assign wm1      = wm1_full[IW-1:0];

    // left neighbor of column c is c-1, column 0 wraps to width-1
    function automatic logic [MAX_WIDTH-1:0] left_of(input logic [MAX_WIDTH-1:0] v,
                                                      input logic [IW-1:0] last);
        return {v[MAX_WIDTH-2:0], v[last]};
    endfunction

    // right neighbor of column c is c+1, column width-1 wraps to 0
    function automatic logic [MAX_WIDTH-1:0] right_of(input logic [MAX_WIDTH-1:0] v,
                                                       input logic [IW-1:0] last);
        logic [MAX_WIDTH-1:0] r;
        r = {1'b0, v[MAX_WIDTH-1:1]};
        r[last] = v[0];
        return r;
    endfunction

    assign up_l  = left_of(i_up, wm1);
    assign up_r  = right_of(i_up, wm1);
    assign cur_l = left_of(i_cur, wm1);
    assign cur_r = right_of(i_cur, wm1);
    assign dn_l  = left_of(i_dn, wm1);
    assign dn_r  = right_of(i_dn, wm1);

    always_comb begin
        logic [3:0] sum;
        for (int c = 0; c < MAX_WIDTH; c++) begin
            sum = 4'(up_l[c]) + 4'(i_up[c]) + 4'(up_r[c])
                + 4'(cur_l[c]) + 4'(cur_r[c])
                + 4'(dn_l[c]) + 4'(i_dn[c]) + 4'(dn_r[c]);
            if (EW'(c) >= i_width) begin
                o_next[c] = i_cur[c];
            end else if (i_cur[c]) begin
                o_next[c] = (sum == 4'd2) || (sum == 4'd3);
            end else begin
                o_next[c] = (sum == 4'd3);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/life_automaton_torus.sv
`timescale 1ns / 1ps
`default_nettype none

// life on a torus, rule b3/s23, grid held in a ring of row cells
// write, unused kind, read outside the area: strobe in the cycle after the accepted beat, no busy
// read: one full turn of the row ring; advance: one turn of the ring computing one row per cycle,
// then a fix-up step for row 0
// results cannot be stalled; o_done is high for one cycle, a new beat can be taken with it
// synchronous active-low reset: all cells dead, width and height registers 64, idle

module life_automaton_torus
    import lat_pkg::*;
#(
    parameter int MAX_WIDTH  = LAT_MAX_WIDTH,
    parameter int MAX_HEIGHT = LAT_MAX_HEIGHT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command side
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [ROW_W-1:0]  i_row,
    input  wire logic [COL_W-1:0]  i_column,
    input  wire logic              i_alive_in,
    // result side
    output logic                   o_done,
    output logic                   o_alive_out,
    output logic [KIND_W-1:0]      o_done_kind,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int EW   = $clog2(MAX_WIDTH + 1);   // effective width
    localparam int EHW  = $clog2(MAX_HEIGHT + 1);  // effective height
    localparam int IW   = $clog2(MAX_WIDTH);       // column index
    localparam int STW  = $clog2(MAX_HEIGHT);      // ring step counter
    localparam int SWW  = (EW > SIZE_W) ? EW : SIZE_W;
    localparam int SWH  = (EHW > SIZE_W) ? EHW : SIZE_W;
    localparam int CMPW = (EHW > ROW_W) ? EHW : ROW_W;
    localparam int CMPC = (EW > COL_W) ? EW : COL_W;

    // ------------------------------------------------------------------
    // configuration registers, decoded on paddr[2] only
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] r_width, n_width;
    logic [SIZE_W-1:0] r_height, n_height;
    logic              cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  n_width  = pwdata[SIZE_W-1:0];
                REG_HEIGHT: n_height = pwdata[SIZE_W-1:0];
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(r_height) : 32'(r_width);

    // saturate the raw sizes to 3..MAX
    logic [SWW-1:0] w_ext;
    logic [SWH-1:0] h_ext;
    logic [EW-1:0]  w_eff;
    logic [EHW-1:0] h_eff;

    assign w_ext = SWW'(r_width);
    assign h_ext = SWH'(r_height);

    always_comb begin
        if (w_ext < SWW'(3)) begin
            w_eff = EW'(3);
        end else if (w_ext > SWW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext[EW-1:0];
        end
        if (h_ext < SWH'(3)) begin
            h_eff = EHW'(3);
        end else if (h_ext > SWH'(MAX_HEIGHT)) begin
            h_eff = EHW'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext[EHW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // ring of row cells: at rest cell i holds row i; during a turn the ring
    // moves toward cell 0, so at step k the head (cell 0) holds row k and
    // cell 1 holds row k+1; the tail (last cell) takes the head's row or,
    // during an advance and for rows 1 to height-1, the new generation of that row
    // ------------------------------------------------------------------
    t_cell_ctl            cell_ctl;
    logic [MAX_WIDTH-1:0] cell_row [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] tail_in;
    logic [MAX_WIDTH-1:0] head;
    logic [MAX_WIDTH-1:0] new_row;
    logic                 load_head;

    assign head = cell_row[0];

    for (genvar i = 0; i < MAX_HEIGHT; i++) begin : g_ring
        if (i == MAX_HEIGHT - 1) begin : g_tail
            lat_row_cell #(
                .MAX_WIDTH (MAX_WIDTH),
                .INDEX     (i)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (cell_ctl),
                .i_shift_in (tail_in),
                .i_load     (1'b0),
                .i_load_row (new_row),
                .o_row      (cell_row[i])
            );
        end else if (i == 0) begin : g_head
            lat_row_cell #(
                .MAX_WIDTH (MAX_WIDTH),
                .INDEX     (i)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (cell_ctl),
                .i_shift_in (cell_row[i+1]),
                .i_load     (load_head),
                .i_load_row (new_row),
                .o_row      (cell_row[i])
            );
        end else begin : g_mid
            lat_row_cell #(
                .MAX_WIDTH (MAX_WIDTH),
                .INDEX     (i)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (cell_ctl),
                .i_shift_in (cell_row[i+1]),
                .i_load     (1'b0),
                .i_load_row (new_row),
                .o_row      (cell_row[i])
            );
        end
    end

    // ------------------------------------------------------------------
    // generation logic, shared between the turn and the row 0 fix-up
    // ------------------------------------------------------------------
    t_state               r_state, n_state;
    logic [STW-1:0]       r_step, n_step;
    logic [MAX_WIDTH-1:0] r_prev, n_prev;     // old row step-1
    logic [MAX_WIDTH-1:0] r_first, n_first;   // old row 0
    logic [MAX_WIDTH-1:0] r_second, n_second; // old row 1
    logic [MAX_WIDTH-1:0] r_last, n_last;     // old row height-1
    logic [MAX_WIDTH-1:0] rule_up, rule_dn;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [COL_W-1:0]     r_col, n_col;
    logic                 r_hit, n_hit;       // read bit captured during the turn
    logic                 r_done, n_done;
    logic                 r_alive, n_alive;
    logic [KIND_W-1:0]    r_dkind, n_dkind;

    logic                 accept;
    logic                 in_area;
    logic                 step_last_row;
    logic                 step_is_row;
    logic                 step_in_grid;
    logic                 step_end;
    logic                 fix;
    logic                 adv;
    logic [IW-1:0]        col_idx;

    assign accept  = start && !busy;
    assign in_area = (CMPW'(i_row) < CMPW'(h_eff)) && (CMPC'(i_column) < CMPC'(w_eff));

    assign step_last_row = (CMPW'(r_step) == CMPW'(h_eff) - CMPW'(1));
    assign step_is_row   = (CMPW'(r_step) == CMPW'(r_row));
    assign step_in_grid  = (r_step != '0) && (CMPW'(r_step) < CMPW'(h_eff));
    assign step_end      = (r_step == STW'(MAX_HEIGHT - 1));
    assign fix           = (r_state == ST_FIX);
    assign adv           = (r_dkind == KIND_ADVANCE);
    assign col_idx       = IW'(r_col);

    // row 0 is done last: its upper neighbor is only seen at the end of the turn
    assign rule_up = fix ? r_last : r_prev;
    assign rule_dn = fix ? r_second : (step_last_row ? r_first : cell_row[1]);

    lat_row_rule #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_rule (
        .i_up    (rule_up),
        .i_cur   (head),
        .i_dn    (rule_dn),
        .i_width (w_eff),
        .o_next  (new_row)
    );

    assign tail_in = (adv && step_in_grid) ? new_row : head;

    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        n_prev          = r_prev;
        n_first         = r_first;
        n_second        = r_second;
        n_last          = r_last;
        n_row           = r_row;
        n_col           = r_col;
        n_hit           = r_hit;
        n_done          = 1'b0;
        n_alive         = 1'b0;
        n_dkind         = r_dkind;
        load_head       = 1'b0;
        cell_ctl.shift  = 1'b0;
        cell_ctl.wr_en  = 1'b0;
        cell_ctl.wr_row = i_row;
        cell_ctl.wr_col = i_column;
        cell_ctl.wr_val = i_alive_in;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_dkind = i_kind;
                    n_row   = i_row;
                    n_col   = i_column;
                    n_hit   = 1'b0;
                    n_step  = '0;
                    // write and unused kinds finish in the accept cycle
                    unique case (i_kind)
                        KIND_WRITE: begin
                            cell_ctl.wr_en = in_area;
                            n_done         = 1'b1;
                        end
                        KIND_READ: begin
                            n_hit   = 1'b0;
                            n_state = in_area ? ST_ROT : ST_IDLE;
                            n_done  = !in_area;
                        end
                        KIND_ADVANCE: begin
                            n_state = ST_ROT;
                        end
                        KIND_NONE: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_ROT: begin
                cell_ctl.shift = 1'b1;
                n_prev         = head;
                n_step         = r_step + STW'(1);
                if (r_step == '0) begin
                    n_first  = head;
                    n_second = cell_row[1];
                end
                if (step_last_row) begin
                    n_last = head;
                end
                if (!adv && step_is_row) begin
                    n_hit = head[col_idx];
                end
                if (step_end) begin
                    n_step = '0;
                    if (adv) begin
                        n_state = ST_FIX;
                    end else begin
                        n_state = ST_IDLE;
                        n_done  = 1'b1;
                        n_alive = step_is_row ? head[col_idx] : r_hit;
                    end
                end
            end
            ST_FIX: begin
                load_head = 1'b1;
                n_done    = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_done   <= 1'b0;
            r_alive  <= 1'b0;
            r_dkind  <= KIND_WRITE;
            r_width  <= SIZE_W'(64);
            r_height <= SIZE_W'(64);
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_done   <= n_done;
            r_alive  <= n_alive;
            r_dkind  <= n_dkind;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    // row buffers and the latched access address
    always_ff @(posedge i_clk) begin
        r_prev   <= n_prev;
        r_first  <= n_first;
        r_second <= n_second;
        r_last   <= n_last;
        r_row    <= n_row;
        r_col    <= n_col;
        r_hit    <= n_hit;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_alive_out = r_alive;
    assign o_done_kind = r_dkind;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_fix_ends_beat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIX) |=> (o_done && (o_done_kind == KIND_ADVANCE) && !busy))
        else $error("advance fix-up did not end in a result beat");

    a_alive_only_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_done_kind != KIND_READ)) |-> !o_alive_out)
        else $error("alive_out set on a non-read result");

    a_advance_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_kind == KIND_ADVANCE)) |-> ##(MAX_HEIGHT + 2) o_done)
        else $error("advance result not delivered after one ring turn");

    a_no_done_mid_turn : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_ROT) && !step_end) |=> !o_done)
        else $error("result beat during a ring turn");

endmodule

`default_nettype wire
